>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/mrp_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte function for the poller.
// No dependencies; used by the top level, mrp_rx, mrp_req and mrp_out.
package mrp_pkg;

	localparam int MAX_FRAME = 256;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int REQ_LEN   = 8;
	localparam int IDX_W     = $clog2(REQ_LEN);
	localparam int HDR_LEN   = 5;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
	localparam logic [7:0]  MIN_BYTE_COUNT = 8'd4;
	localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(7);

	localparam logic [7:0]  SLAVE_RST    = 8'h01;
	localparam logic [15:0] INTERVAL_RST = 16'd100;
	localparam logic [15:0] REG_ADDR_RST = 16'h0000;
	localparam logic [6:0]  REG_CNT_RST  = 7'd2;

	localparam logic KIND_REQ     = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_BYTE = 2'd1,
		ACT_IDLE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CRC   = 2'd1,
		ST_HDR   = 2'd2,
		ST_SHORT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_SLAVE     = 2'd0,
		CFG_INTERVAL  = 2'd1,
		CFG_REG_ADDR  = 2'd2,
		CFG_REG_COUNT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [15:0] poll_interval_ticks;
		logic [15:0] register_address;
		logic [6:0]  register_count;
	} cfg_t;

	// Receive side view: verdict of a frame end plus held value before/after it.
	typedef struct packed {
		status_t     status;
		logic [15:0] nxt_value;
		logic        nxt_valid;
		logic [15:0] cur_value;
		logic        cur_valid;
	} rx_view_t;

	// One output run: eight request bytes or one verdict.
	typedef struct packed {
		logic                   kind;
		logic [REQ_LEN-1:0][7:0] bytes;
		status_t                status;
		logic [15:0]            value;
		logic                   value_valid;
	} run_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/modbus_rtu_register_poller_top.sv
// Top level of the Modbus RTU holding-register poller.
// Depends on mrp_pkg, mrp_rx, mrp_req and mrp_out.
//
// Modbus RTU master for one holding-register group. Input transactions carry an action in
// s_tuser (0 millisecond tick, 1 received byte in s_tdata, 2 line idle / frame end; 3 is
// ignored). Every poll_interval_ticks ticks the block sends an 8-byte function 0x03 request,
// CRC low byte first, as eight output transactions with tuser=0 and tlast on the eighth.
// A frame end gives one verdict transaction (tuser=1, tlast=1): status 0 accepted, 1 CRC
// mismatch, 2 header mismatch (address, function, byte count below 4), 3 fewer than 7 bytes.
// Bytes past 256 in one frame are dropped. Every output transaction also carries the held
// raw value (first data register, tenths of a unit) and its sticky valid flag.
// Rate: one input transaction per cycle while no item waits for the output register. An
// accepted item is held in the input register and then loaded into the output register,
// from which its first output transaction is taken.
// Ticks that do not fire, received bytes and unused actions never wait for the output
// register. A firing tick occupies the output register for eight beats and a verdict for
// one; an item that produces output waits in the input register until the previous run's
// last beat is taken, and holds off the input meanwhile.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) apply at the next edge and must be
// made while the block is idle.
module modbus_rtu_register_poller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] tx_byte, [9:8] frame_status,
	                               // [25:10] raw_value, [26] value_valid, [31:27] zero
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast    // last_of_run
);

	mrp_pkg::cfg_t     cfg_q;
	logic              valid_s1;
	logic [1:0]        act_s1;
	logic [7:0]        byte_s1;

	mrp_pkg::rx_view_t view;
	mrp_pkg::run_t     run;
	logic [mrp_pkg::REQ_LEN-1:0][7:0] req_bytes;
	logic              fire;
	logic              out_free;
	logic              produces;
	logic              consume;
	logic              load;
	logic              rx_en;
	logic              tick_en;
	logic              is_tick;
	logic              is_idle;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address       <= mrp_pkg::SLAVE_RST;
			cfg_q.poll_interval_ticks <= mrp_pkg::INTERVAL_RST;
			cfg_q.register_address    <= mrp_pkg::REG_ADDR_RST;
			cfg_q.register_count      <= mrp_pkg::REG_CNT_RST;
		end else if (cfg_wr_en) begin
			unique case (mrp_pkg::cfg_idx_t'(cfg_index))
				mrp_pkg::CFG_SLAVE:     cfg_q.slave_address       <= cfg_data[7:0];
				mrp_pkg::CFG_INTERVAL:  cfg_q.poll_interval_ticks <= cfg_data;
				mrp_pkg::CFG_REG_ADDR:  cfg_q.register_address    <= cfg_data;
				mrp_pkg::CFG_REG_COUNT: cfg_q.register_count      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register
	assign is_tick  = (act_s1 == mrp_pkg::ACT_TICK);
	assign is_idle  = (act_s1 == mrp_pkg::ACT_IDLE);
	assign produces = (is_tick && fire) || is_idle;
	// items without output retire at once; others need the output register
	assign consume  = valid_s1 && (!produces || out_free);
	assign load     = consume && produces;
	assign s_tready = !valid_s1 || consume;
	assign tick_en  = consume && is_tick;
	assign rx_en    = consume && !is_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	mrp_rx u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_en         (rx_en),
		.action        (act_s1),
		.rx_byte       (byte_s1),
		.slave_address (cfg_q.slave_address),
		.view          (view)
	);

	mrp_req u_req (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (tick_en),
		.cfg       (cfg_q),
		.fire      (fire),
		.req_bytes (req_bytes)
	);

	// build the run for the output register
	always_comb begin
		if (is_idle) begin
			run.kind        = mrp_pkg::KIND_VERDICT;
			run.bytes       = '0;
			run.status      = view.status;
			run.value       = view.nxt_value;
			run.value_valid = view.nxt_valid;
		end else begin
			run.kind        = mrp_pkg::KIND_REQ;
			run.bytes       = req_bytes;
			run.status      = mrp_pkg::ST_OK;
			run.value       = view.cur_value;
			run.value_valid = view.cur_valid;
		end
	end

	mrp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.run      (run),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

>>> rtl/mrp_rx.sv
// Receive frame tracker: byte count, delayed running CRC, header capture, verdict.
// Depends on mrp_pkg.
module mrp_rx (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_en,
	input  logic [1:0]          action,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          slave_address,
	output mrp_pkg::rx_view_t   view
);

	logic [mrp_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]               crc_q;
	logic [1:0][7:0]           tail_q;
	logic [mrp_pkg::HDR_LEN-1:0][7:0] hdr_q;
	logic [15:0]               held_value_q;
	logic                      held_valid_q;

	logic        full;
	logic        short_frame;
	logic [15:0] crc_upd;
	logic [15:0] frame_fcs;

	assign full        = (cnt_q >= mrp_pkg::CNT_W'(mrp_pkg::MAX_FRAME));
	assign short_frame = (cnt_q < mrp_pkg::MIN_FRAME);
	assign crc_upd     = mrp_pkg::crc_byte(crc_q, tail_q[0]);
	assign frame_fcs   = {tail_q[1], tail_q[0]};

	always_comb begin
		view.cur_value = held_value_q;
		view.cur_valid = held_valid_q;
		view.nxt_value = held_value_q;
		view.nxt_valid = held_valid_q;
		if (short_frame) begin
			view.status = mrp_pkg::ST_SHORT;
		end else if (frame_fcs != crc_q) begin
			view.status = mrp_pkg::ST_CRC;
		end else if (hdr_q[0] != slave_address || hdr_q[1] != mrp_pkg::FUNC_READ_HOLD ||
				hdr_q[2] < mrp_pkg::MIN_BYTE_COUNT) begin
			view.status = mrp_pkg::ST_HDR;
		end else begin
			view.status    = mrp_pkg::ST_OK;
			view.nxt_value = {hdr_q[3], hdr_q[4]};
			view.nxt_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			crc_q        <= mrp_pkg::CRC_INIT;
			tail_q       <= '0;
			hdr_q        <= '0;
			held_value_q <= '0;
			held_valid_q <= 1'b0;
		end else if (rx_en) begin
			if (action == mrp_pkg::ACT_IDLE) begin
				held_value_q <= view.nxt_value;
				held_valid_q <= view.nxt_valid;
				cnt_q        <= '0;
				crc_q        <= mrp_pkg::CRC_INIT;
				tail_q       <= '0;
				hdr_q        <= '0;
			end else if (action == mrp_pkg::ACT_BYTE && !full) begin
				// CRC runs two bytes behind so it never covers the received CRC
				if (cnt_q >= mrp_pkg::CNT_W'(2)) begin
					crc_q <= crc_upd;
				end
				tail_q[0] <= tail_q[1];
				tail_q[1] <= rx_byte;
				for (int h = 0; h < mrp_pkg::HDR_LEN; h++) begin
					if (cnt_q == mrp_pkg::CNT_W'(h)) begin
						hdr_q[h] <= rx_byte;
					end
				end
				cnt_q <= cnt_q + mrp_pkg::CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/mrp_req.sv
// Poll timer and read-holding-register request builder with CRC-16/Modbus.
// Depends on mrp_pkg.
module mrp_req (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick_en,
	input  mrp_pkg::cfg_t                       cfg,
	output logic                                fire,
	output logic [mrp_pkg::REQ_LEN-1:0][7:0]    req_bytes
);

	logic [15:0] tick_q;
	logic [15:0] tick_nxt;
	logic [15:0] crc;

	assign tick_nxt = tick_q + 16'd1;
	// an interval of zero behaves like one
	assign fire     = (tick_nxt >= cfg.poll_interval_ticks);

	// Six chained byte updates over config only; a linear map that flattens to XOR trees.
	always_comb begin
		req_bytes[0] = cfg.slave_address;
		req_bytes[1] = mrp_pkg::FUNC_READ_HOLD;
		req_bytes[2] = cfg.register_address[15:8];
		req_bytes[3] = cfg.register_address[7:0];
		req_bytes[4] = 8'h00;
		req_bytes[5] = {1'b0, cfg.register_count};
		crc = mrp_pkg::CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			crc = mrp_pkg::crc_byte(crc, req_bytes[i]);
		end
		req_bytes[6] = crc[7:0];
		req_bytes[7] = crc[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (tick_en) begin
			tick_q <= fire ? 16'd0 : tick_nxt;
		end
	end

endmodule

>>> rtl/mrp_out.sv
// Output run register: shifts out eight request bytes or presents one verdict.
// Depends on mrp_pkg.
module mrp_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  mrp_pkg::run_t run,
	output logic          out_free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tuser,
	output logic          m_tlast
);

	logic                                valid_q;
	logic                                kind_q;
	logic [mrp_pkg::REQ_LEN-1:0][7:0]    bytes_q;
	logic [mrp_pkg::IDX_W-1:0]           idx_q;
	logic [1:0]                          status_q;
	logic [15:0]                         value_q;
	logic                                vvalid_q;
	logic                                beat;

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = (kind_q == mrp_pkg::KIND_VERDICT) ||
		(idx_q == mrp_pkg::IDX_W'(mrp_pkg::REQ_LEN - 1));
	assign m_tdata  = {5'd0, vvalid_q, value_q, status_q, bytes_q[0]};
	assign beat     = valid_q && m_tready;
	assign out_free = !valid_q || (beat && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (beat) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + mrp_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= run.kind;
			bytes_q  <= run.bytes;
			status_q <= run.status;
			value_q  <= run.value;
			vvalid_q <= run.value_valid;
		end else if (beat) begin
			bytes_q <= {8'h00, bytes_q[mrp_pkg::REQ_LEN-1:1]};
		end
	end

endmodule

>>> rtl/mrp_checker.sv
// Port-level checker for the poller output stream, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a verdict is always a run of one
	`AST_IMP(a_verdict_last, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	// request bytes carry no status
	`AST_IMP(a_req_status, clk, arst_n, m_tvalid && !m_tuser, m_tdata[9:8] == 2'd0)
	// an accepted frame always leaves the value marked valid
	`AST_IMP(a_ok_valid, clk, arst_n, m_tvalid && m_tuser && m_tdata[9:8] == 2'd0,
		m_tdata[26])
	// a stalled transaction holds
	`AST_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind modbus_rtu_register_poller_top mrp_checker u_mrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
